FILE: hw/rtl/sli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list package
// Types, constants and codes shared by the sorted list controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int RSP_CNT_W  = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [RSP_CNT_W-1:0] count;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_sts;

endpackage : sli_pkg
`default_nettype wire

FILE: hw/rtl/sli_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list controller
// Two-state sequencer: captures a request with its compare flags, then
// applies the table update once the result register can take the result.
// ----------------------------------------------------------------------------
module sli_ctrl import sli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!i_sts.out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall       = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.apply   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_APPLY: begin
                o_cmd.apply = !i_sts.out_blocked;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule : sli_ctrl
`default_nettype wire

FILE: hw/rtl/sli_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list datapath
// Shift-register table with one comparator pair per entry, registered
// compare flags, the entry count and the result register.
// ----------------------------------------------------------------------------
module sli_dp import sli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    input  wire logic i_stall,
    output t_sts      o_sts,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    logic [VALUE_W-1:0]  r_vals [CAPACITY];
    logic [VALUE_W-1:0]  n_vals [CAPACITY];
    logic [VALUE_W-1:0]  up_src [CAPACITY];
    logic [VALUE_W-1:0]  dn_src [CAPACITY];
    logic [CAPACITY-1:0] r_ge;
    logic [CAPACITY-1:0] n_ge;
    logic [CAPACITY-1:0] r_eq;
    logic [CAPACITY-1:0] n_eq;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_type;
    logic [VALUE_W-1:0]  r_value;
    logic                r_out_valid;
    t_rsp                r_rsp;
    t_rsp                n_rsp;
    logic                full;
    logic                found;
    logic                do_up;
    logic                do_down;

    always_comb begin
        full    = (r_count == CNT_W'(CAPACITY));
        found   = |r_eq;
        do_up   = (r_type == REQ_INSERT) && !full;
        do_down = (r_type == REQ_DELETE) && found;
        n_count = r_count;
        n_rsp.status = ST_DONE;
        if (r_type == REQ_INSERT) begin
            if (full) begin
                n_rsp.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_rsp.status = ST_NO_MATCH;
            end
        end
        n_rsp.count = RSP_CNT_W'(n_count);
    end

    // Entries at or above the count report greater-or-equal, so the flags
    // form a single rising step that marks the insert or delete position.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign n_ge[g] = (CNT_W'(g) >= r_count) ||
                         ($signed(i_req.value) <= $signed(r_vals[g]));
        assign n_eq[g] = (CNT_W'(g) < r_count) && (i_req.value == r_vals[g]);

        if (g == 0) begin : g_first
            assign up_src[g] = r_value;
        end else begin : g_rest
            assign up_src[g] = r_ge[g-1] ? r_vals[g-1] : r_value;
        end

        if (g == CAPACITY - 1) begin : g_last
            assign dn_src[g] = r_vals[g];
        end else begin : g_inner
            assign dn_src[g] = r_vals[g+1];
        end

        assign n_vals[g] = (do_up && r_ge[g])   ? up_src[g] :
                           (do_down && r_ge[g]) ? dn_src[g] : r_vals[g];

        always_ff @(posedge i_clk) begin
            if (i_cmd.apply) begin
                r_vals[g] <= n_vals[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req.req_type;
            r_value <= i_req.value;
            r_ge    <= n_ge;
            r_eq    <= n_eq;
        end
        if (i_cmd.apply) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.out_blocked = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_rsp             = r_rsp;

endmodule : sli_dp
`default_nettype wire

FILE: hw/rtl/sorted_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert and delete: a request and its compare flags are registered, then the table shift
// and result register update follow once the result register is free; new requests stall until done.
// Synchronous active-low reset empties the list; stored values are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete import sli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    t_cmd cmd;
    t_sts sts;

    sli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sli_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule : sorted_list_insert_delete
`default_nettype wire

FILE: hw/rtl/sli_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list checker
// Port-level properties of the sorted list block, bound to the top level.
// ----------------------------------------------------------------------------
module sli_checker import sli_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_rsp o_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result withdrawn while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_rsp))
        else $error("Result changed while stalled.");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Request taken while the previous one is still in progress.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_DONE || o_rsp.status == ST_NO_MATCH ||
                     o_rsp.status == ST_FULL))
        else $error("Undefined status code.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((CAPACITY > 31) || (int'(o_rsp.count) <= CAPACITY)))
        else $error("Count exceeds the table capacity.");

endmodule : sli_checker

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);
`default_nettype wire
